// ===== sv/assert_macros.svh =====
// Assertion macros shared by the codec RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define VZC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define VZC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/vzc_pkg.sv =====
// Types and constants of the varint / zigzag codec.
// No dependencies; imported by every codec module.
package vzc_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned GROUP_W = 7;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned SHAMT_W = 6;

   localparam logic [COUNT_W-1:0] LIMIT32 = 4'd6;
   localparam logic [COUNT_W-1:0] LIMIT64 = 4'd10;

   // request codes
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic              wide;
      logic              zigzag;
      logic [WORD_W-1:0] value;
      logic [7:0]        in_byte;
   } vzc_req_type;

   typedef struct packed {
      logic [1:0]        out_kind;
      logic [7:0]        out_byte;
      logic [WORD_W-1:0] out_value;
      logic              last;
   } vzc_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_ENC
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic sel_w;     // take encode bits from the shift register
      logic enc_emit;  // emit one encoded byte
      logic dec_take;  // take one decode byte
   } vzc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // output register can load this cycle
      logic enc_done;  // current encode byte is the final one
   } vzc_status_type;

endpackage

// ===== sv/varint_zigzag_codec.sv =====
// Varint / zigzag codec top: controller plus datapath. Depends on vzc_pkg, vzc_ctrl, vzc_dp.
// Encode: one output byte per cycle unless stalled; 1..10 per item, one per 7-bit group.
// Decode: one byte in per cycle unless stalled; a result is registered on the accept edge.
// The result is registered: it appears in the cycle after the accept or step that made it.
// Reset (synchronous, active high) clears the decoder accumulator and count,
// the output valid and the encode sequencer; payload registers are not reset.
module varint_zigzag_codec
   import vzc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vzc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output vzc_rsp_type rsp_data
);

   vzc_cmd_type    cmd;
   vzc_status_type status;

   // Controller: takes an item when idle and the output register has room,
   // then walks the remaining encode groups one per free output slot.
   vzc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: zigzag mapping, 7-bit group shifter, decode accumulator,
   // and the output register that decouples the result side.
   vzc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

// ===== sv/vzc_ctrl.sv =====
// Controller of the varint / zigzag codec: accept and encode sequencing.
// Depends on vzc_pkg.
module vzc_ctrl
   import vzc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_kind,
   output logic           req_ready,
   input  vzc_status_type status,
   output vzc_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_kind == REQ_ENCODE) begin
                  cmd.enc_emit = 1'b1;
                  if (!status.enc_done) begin
                     state_in = ST_ENC;
                  end
               end else begin
                  cmd.dec_take = 1'b1;
               end
            end
         end
         ST_ENC: begin
            cmd.sel_w = 1'b1;
            if (status.out_free) begin
               cmd.enc_emit = 1'b1;
               if (status.enc_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/vzc_dp.sv =====
// Datapath of the varint / zigzag codec: encode shifter, decode
// accumulator and output register. Depends on vzc_pkg, assert_macros.svh.
`include "assert_macros.svh"
module vzc_dp
   import vzc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  vzc_req_type    req,
   input  vzc_cmd_type    cmd,
   output vzc_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output vzc_rsp_type    rsp
);

   logic [WORD_W-1:0]  w_ff, w_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vzc_rsp_type        rsp_ff, rsp_in;

   logic [HALF_W-1:0]  w32;
   logic [WORD_W-1:0]  mapped;
   logic [WORD_W-1:0]  src;
   logic [WORD_W-1:0]  rest;
   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] cnt_inc;
   logic [SHAMT_W-1:0] shamt;
   logic [WORD_W-1:0]  acc_new;
   logic [HALF_W-1:0]  unzz;
   logic               dec_emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   // encode: map the word, then peel off 7-bit groups
   always_comb begin
      status.out_free = !rsp_valid_ff || rsp_ready;
      w32 = req.value[HALF_W-1:0];
      if (req.wide) begin
         mapped = req.value;
      end else if (req.zigzag) begin
         mapped = {{HALF_W{1'b0}}, {w32[HALF_W-2:0], 1'b0} ^ {HALF_W{w32[HALF_W-1]}}};
      end else begin
         mapped = {{HALF_W{1'b0}}, w32};
      end
      src  = cmd.sel_w ? w_ff : mapped;
      rest = src >> GROUP_W;
      status.enc_done = (rest == '0);
   end

   // decode: place the group at 7 * count, mask to the mode width
   always_comb begin
      limit   = req.wide ? LIMIT64 : LIMIT32;
      cnt_inc = cnt_ff + 1'b1;
      shamt   = ({2'b00, cnt_ff} << 3) - {2'b00, cnt_ff};
      acc_new = acc_ff | ({{(WORD_W-GROUP_W){1'b0}}, req.in_byte[GROUP_W-1:0]} << shamt);
      if (!req.wide) begin
         acc_new[WORD_W-1:HALF_W] = '0;
      end
      unzz = acc_new[HALF_W:1] ^ {HALF_W{acc_new[0]}};
   end

   always_comb begin
      w_in         = w_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      dec_emit     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.enc_emit) begin
         w_in             = rest;
         rsp_in.out_kind  = KIND_BYTE;
         rsp_in.out_byte  = {!status.enc_done, src[GROUP_W-1:0]};
         rsp_in.out_value = '0;
         rsp_in.last      = status.enc_done;
         rsp_valid_in     = 1'b1;
      end

      if (cmd.dec_take) begin
         rsp_in.out_byte  = '0;
         rsp_in.out_value = '0;
         rsp_in.last      = 1'b1;
         if (cnt_ff >= limit) begin
            // mode switched past its limit: drop the byte
            rsp_in.out_kind = KIND_ERROR;
            dec_emit        = 1'b1;
            acc_in          = '0;
            cnt_in          = '0;
         end else if (!req.in_byte[GROUP_W]) begin
            rsp_in.out_kind = KIND_VALUE;
            if (!req.wide && req.zigzag) begin
               rsp_in.out_value = {{HALF_W{1'b0}}, unzz};
            end else begin
               rsp_in.out_value = acc_new;
            end
            dec_emit = 1'b1;
            acc_in   = '0;
            cnt_in   = '0;
         end else if (cnt_inc >= limit) begin
            rsp_in.out_kind = KIND_ERROR;
            dec_emit        = 1'b1;
            acc_in          = '0;
            cnt_in          = '0;
         end else begin
            acc_in = acc_new;
            cnt_in = cnt_inc;
         end
         if (dec_emit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      rsp_ff <= rsp_in;
   end

   `VZC_ASSERT_IMP(a_emit_has_room, clock, reset, cmd.enc_emit || cmd.dec_take,
      status.out_free, "item emitted while output register is full")
   `VZC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff < LIMIT64,
      "group count reached the wide limit")
   `VZC_ASSERT_IMP(a_enc_pending, clock, reset, cmd.sel_w, w_ff != '0,
      "encode sequencing with no bits left")
   `VZC_ASSERT_NEXT(a_count_step, clock, reset,
      cmd.dec_take && req.in_byte[GROUP_W] && cnt_ff < limit && cnt_inc < limit,
      cnt_ff == $past(cnt_inc), "continuation byte did not advance the count")

endmodule
